@@ rtl/bdq_pkg.sv @@
package bdq_pkg;

  localparam int WORD_W = 32;

  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_REM_FIRST  = 3'd4,
    KIND_REM_ALL    = 3'd5,
    KIND_EXISTS     = 3'd6,
    KIND_CLEAR      = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic scan_step;
    logic scan_end;
    logic rd_front;
    logic rd_back;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic  search;
    logic  empty;
    logic  scan_done;
    logic  out_busy;
  } sts_t;

endpackage

@@ rtl/bdq_ram.sv @@
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/bdq_ctrl.sv @@
module bdq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  bdq_pkg::sts_t sts,
  output bdq_pkg::cmd_t cmd
);

  import bdq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_RD_FRONT,
    S_RD_BACK,
    S_FIN
  } state_t;

  state_t state;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.load_item = (state == S_IDLE) && in_valid;
    cmd.exec      = (state == S_EXEC);
    cmd.scan_step = (state == S_SCAN) && !sts.scan_done;
    cmd.scan_end  = (state == S_SCAN) && sts.scan_done;
    cmd.rd_front  = (state == S_RD_FRONT);
    cmd.rd_back   = (state == S_RD_BACK);
    cmd.load_out  = (state == S_FIN) && !sts.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= (sts.search && !sts.empty) ? S_SCAN : S_RD_FRONT;
        end
        S_SCAN: begin
          if (sts.scan_done) state <= S_RD_FRONT;
        end
        S_RD_FRONT: state <= S_RD_BACK;
        S_RD_BACK:  state <= S_FIN;
        S_FIN: begin
          if (!sts.out_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_read: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.scan_step, cmd.rd_front, cmd.rd_back}))
    else $error("more than one read source selected");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_item |=> (state == S_EXEC))
    else $error("accepted transaction did not start execution");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && sts.out_busy |=> (state == S_FIN))
    else $error("left finish while result still pending");

endmodule

@@ rtl/bdq_dp.sv @@
module bdq_dp #(
  parameter int CAPACITY = 64,
  parameter int CW       = 7
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bdq_pkg::cmd_t               cmd,
  output bdq_pkg::sts_t               sts,
  input  logic [2:0]                  kind,
  input  logic signed [31:0]          value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic                        found,
  output logic signed [31:0]          front_value,
  output logic signed [31:0]          back_value,
  output logic [CW-1:0]               count
);

  import bdq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] CAP_S  = SW'(CAPACITY);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [CW-1:0] p);
    logic [SW-1:0] s;
    s = {{(SW-AW){1'b0}}, h} + {1'b0, p};
    if (s >= CAP_S) s = s - CAP_S;
    return s[AW-1:0];
  endfunction

  kind_t              op;
  logic signed [31:0] key;
  logic [AW-1:0]      head;
  logic [CW-1:0]      held;
  status_t            res;
  logic               hit;
  logic [CW-1:0]      rd_i;
  logic [CW-1:0]      wr_i;
  logic               pend;
  logic signed [31:0] front_q;

  logic               we, re;
  logic [AW-1:0]      waddr, raddr;
  logic [31:0]        wdata, rdata;

  logic               empty, full, search, match, skip;
  logic [AW-1:0]      head_dec, head_inc;
  logic [CW-1:0]      last_pos;

  assign empty    = (held == '0);
  assign full     = (held == CAP_C);
  assign search   = (op == KIND_REM_FIRST) || (op == KIND_REM_ALL) || (op == KIND_EXISTS);
  assign head_dec = (head == '0) ? LAST_A : head - 1'b1;
  assign head_inc = (head == LAST_A) ? '0 : head + 1'b1;
  assign last_pos = empty ? '0 : held - 1'b1;
  assign match    = ($signed(rdata) == key);
  // remove-first drops only the first hit, remove-all every hit
  assign skip     = match && ((op == KIND_REM_ALL) || ((op == KIND_REM_FIRST) && !hit));

  assign sts.search    = search;
  assign sts.empty     = empty;
  assign sts.scan_done = (rd_i == held) && !pend;
  assign sts.out_busy  = out_valid && out_stall;

  always_comb begin
    we    = 1'b0;
    waddr = slot_of(head, wr_i);
    wdata = rdata;
    if (cmd.exec && !full && (op == KIND_PUSH_FRONT)) begin
      we    = 1'b1;
      waddr = head_dec;
      wdata = key;
    end else if (cmd.exec && !full && (op == KIND_PUSH_BACK)) begin
      we    = 1'b1;
      waddr = slot_of(head, held);
      wdata = key;
    end else if (cmd.scan_step && pend && !skip) begin
      we = 1'b1;
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = slot_of(head, rd_i);
    if (cmd.scan_step && (rd_i != held)) begin
      re = 1'b1;
    end else if (cmd.rd_front) begin
      re    = 1'b1;
      raddr = head;
    end else if (cmd.rd_back) begin
      re    = 1'b1;
      raddr = slot_of(head, last_pos);
    end
  end

  bdq_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op  <= kind_t'(kind);
      key <= value;
    end
    if (cmd.rd_back) begin
      front_q <= $signed(rdata);
    end
    if (cmd.exec) begin
      hit  <= 1'b0;
      rd_i <= '0;
      wr_i <= '0;
      case (op)
        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
          res <= full ? ST_FULL : ST_OK;
        end
        KIND_POP_FRONT, KIND_POP_BACK, KIND_REM_FIRST, KIND_REM_ALL, KIND_EXISTS: begin
          res <= empty ? ST_EMPTY : ST_OK;
        end
        default: res <= ST_OK;
      endcase
    end
    if (cmd.scan_step) begin
      if (rd_i != held) rd_i <= rd_i + 1'b1;
      if (pend) begin
        if (match) hit <= 1'b1;
        if (!skip) wr_i <= wr_i + 1'b1;
      end
    end
    if (cmd.scan_end) begin
      res <= hit ? ST_OK : ST_NOT_FOUND;
    end
    if (cmd.load_out) begin
      status      <= res;
      found       <= hit && search;
      count       <= held;
      front_value <= empty ? '0 : front_q;
      back_value  <= empty ? '0 : $signed(rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      held      <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        pend <= 1'b0;
        case (op)
          KIND_PUSH_FRONT: begin
            if (!full) begin
              head <= head_dec;
              held <= held + 1'b1;
            end
          end
          KIND_PUSH_BACK: begin
            if (!full) held <= held + 1'b1;
          end
          KIND_POP_FRONT: begin
            if (!empty) begin
              head <= head_inc;
              held <= held - 1'b1;
            end
          end
          KIND_POP_BACK: begin
            if (!empty) held <= held - 1'b1;
          end
          KIND_CLEAR: begin
            head <= '0;
            held <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.scan_step) begin
        pend <= (rd_i != held);
      end
      if (cmd.scan_end) begin
        held <= wr_i;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    (held <= CAP_C) && (head <= LAST_A))
    else $error("occupancy or head slot out of range");

  a_wr_behind_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step && pend |-> (wr_i < rd_i))
    else $error("compaction write pointer caught up with read pointer");

  a_scan_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_end |=> (held <= $past(held)))
    else $error("scan grew the store");

endmodule

@@ rtl/bounded_deque_with_value_removal.sv @@
// channel | valid     | stall     | payload
// --------+-----------+-----------+--------------------------------------------------
// in      | in_valid  | in_stall  | kind[2:0], value[31:0]
// out     | out_valid | out_stall | status[1:0], found, front_value, back_value, count
//
// Push, pop and clear go from accept through execute, front read, back read and
// finish; remove-first, remove-all and exists on a non-empty store add a scan
// between execute and the front read, walking the word RAM one entry per cycle
// through its single read port.
// A new transaction is taken while the previous result waits on out_stall.
// rst is synchronous; the RAM contents are not cleared, no clearing pass.
module bounded_deque_with_value_removal #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          kind,
  input  logic signed [31:0]                  value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          status,
  output logic                                found,
  output logic signed [31:0]                  front_value,
  output logic signed [31:0]                  back_value,
  output logic [$clog2(CAPACITY+1)-1:0]       count
);

  import bdq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  cmd_t cmd;
  sts_t sts;

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bdq_dp #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .kind        (kind),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found       (found),
    .front_value (front_value),
    .back_value  (back_value),
    .count       (count)
  );

endmodule

@@ test/bounded_deque_with_value_removal_tb.sv @@
module bounded_deque_with_value_removal_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  localparam int DEPTH = 64;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS = 600;

  typedef struct packed {
    status_t                   status;
    logic                      found;
    logic signed [WORD_W-1:0]  front;
    logic signed [WORD_W-1:0]  back;
    logic [CNT_W-1:0]          count;
  } deque_result_t;

  class deque_scoreboard;
    logic signed [WORD_W-1:0] held_words[$];
    deque_result_t            pending_results[$];
    int errors;
    int checked;
    int full_rejects;
    int empty_hits;
    int misses;
    int removals;
    int peak_depth;

    // Apply one accepted transaction to the shadow store and queue its result.
    function void apply_operation(kind_t op, logic signed [WORD_W-1:0] word);
      deque_result_t            res;
      int                       hit;
      logic signed [WORD_W-1:0] kept[$];
      res = '0;
      res.status = ST_OK;
      case (op)
        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
          if (held_words.size() >= DEPTH) begin
            res.status = ST_FULL;
          end else if (op == KIND_PUSH_FRONT) begin
            held_words.push_front(word);
          end else begin
            held_words.push_back(word);
          end
        end
        KIND_POP_FRONT, KIND_POP_BACK: begin
          if (held_words.size() == 0) begin
            res.status = ST_EMPTY;
          end else if (op == KIND_POP_FRONT) begin
            void'(held_words.pop_front());
          end else begin
            void'(held_words.pop_back());
          end
        end
        KIND_REM_FIRST, KIND_REM_ALL, KIND_EXISTS: begin
          if (held_words.size() == 0) begin
            res.status = ST_EMPTY;
          end else begin
            hit = -1;
            foreach (held_words[i]) begin
              if (hit < 0 && held_words[i] == word) hit = i;
            end
            if (hit < 0) begin
              res.status = ST_NOT_FOUND;
            end else begin
              res.found = 1'b1;
              if (op == KIND_REM_FIRST) begin
                held_words.delete(hit);
                removals++;
              end else if (op == KIND_REM_ALL) begin
                foreach (held_words[i]) begin
                  if (held_words[i] != word) kept.push_back(held_words[i]);
                end
                removals += held_words.size() - kept.size();
                held_words = kept;
              end
            end
          end
        end
        default: begin
          held_words.delete();
        end
      endcase
      if (held_words.size() > 0) begin
        res.front = held_words[0];
        res.back  = held_words[held_words.size() - 1];
      end
      res.count = CNT_W'(held_words.size());
      if (res.status == ST_FULL) full_rejects++;
      if (res.status == ST_EMPTY) empty_hits++;
      if (res.status == ST_NOT_FOUND) misses++;
      if (held_words.size() > peak_depth) peak_depth = held_words.size();
      pending_results.push_back(res);
    endfunction

    function void check_result(status_t st, logic fnd, logic signed [WORD_W-1:0] fv,
                               logic signed [WORD_W-1:0] bv, logic [CNT_W-1:0] cnt);
      deque_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: status=%0d count=%0d", $time, st, cnt);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (st !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, st);
      end
      if (fnd !== want.found) begin
        errors++;
        $display("%0t: found expected %0d actual %0d", $time, want.found, fnd);
      end
      if (fv !== want.front) begin
        errors++;
        $display("%0t: front_value expected %0d actual %0d", $time, want.front, fv);
      end
      if (bv !== want.back) begin
        errors++;
        $display("%0t: back_value expected %0d actual %0d", $time, want.back, bv);
      end
      if (cnt !== want.count) begin
        errors++;
        $display("%0t: count expected %0d actual %0d", $time, want.count, cnt);
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [2:0]                kind = '0;
  logic signed [WORD_W-1:0]  value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [1:0]                status;
  logic                      found;
  logic signed [WORD_W-1:0]  front_value;
  logic signed [WORD_W-1:0]  back_value;
  logic [CNT_W-1:0]          count;

  deque_scoreboard sb;
  int items_sent;
  int burst_left;
  int stall_mode;
  int stall_left;

  bounded_deque_with_value_removal #(
    .CAPACITY(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .found(found),
    .front_value(front_value),
    .back_value(back_value),
    .count(count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: free-running, light, heavy and long periodic stall stretches
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(3);
      stall_left = $urandom_range(20, 150);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall = 1'b0;
      1: out_stall = ($urandom_range(99) < 25);
      2: out_stall = ($urandom_range(99) < 70);
      default: out_stall = ((stall_left % 16) < 10);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(status_t'(status), found, front_value, back_value, count);
    end
  end

  task automatic send_item(kind_t op, logic signed [WORD_W-1:0] word);
    int idle_gap;
    @(negedge clk);
    in_valid = 1'b1;
    kind = op;
    value = word;
    do @(posedge clk); while (in_stall);
    sb.apply_operation(op, word);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle_gap = $urandom_range(1, 8);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (idle_gap - 1) @(negedge clk);
    end
  endtask

  // small pool of repeated words so searches hit and duplicates pile up
  function automatic logic signed [WORD_W-1:0] pick_word();
    if ($urandom_range(99) < 45) return $urandom;
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -1;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_key();
    if (sb.held_words.size() > 0 && $urandom_range(99) < 65) begin
      return sb.held_words[$urandom_range(sb.held_words.size() - 1)];
    end
    return pick_word();
  endfunction

  function automatic kind_t pick_kind(logic drain);
    int r;
    r = $urandom_range(99);
    if (drain) begin
      if (r < 20) return KIND_POP_FRONT;
      if (r < 40) return KIND_POP_BACK;
      if (r < 55) return KIND_REM_FIRST;
      if (r < 68) return KIND_REM_ALL;
      if (r < 85) return KIND_EXISTS;
      if (r < 90) return KIND_CLEAR;
      if (r < 95) return KIND_PUSH_FRONT;
      return KIND_PUSH_BACK;
    end
    if (r < 20) return KIND_PUSH_FRONT;
    if (r < 40) return KIND_PUSH_BACK;
    if (r < 50) return KIND_POP_FRONT;
    if (r < 60) return KIND_POP_BACK;
    if (r < 72) return KIND_REM_FIRST;
    if (r < 82) return KIND_REM_ALL;
    if (r < 97) return KIND_EXISTS;
    return KIND_CLEAR;
  endfunction

  initial begin
    int    random_start;
    int    seg_len;
    int    r;
    int    wait_cycles;
    kind_t op;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty store: every pop and search reports empty, clear is still ok
    send_item(KIND_POP_FRONT, 32'sd1);
    send_item(KIND_POP_BACK, 32'sd1);
    send_item(KIND_REM_FIRST, 32'sd0);
    send_item(KIND_REM_ALL, 32'sd0);
    send_item(KIND_EXISTS, 32'sd0);
    send_item(KIND_CLEAR, 32'sd0);
    // extremes and a run of duplicates at the head
    send_item(KIND_PUSH_BACK, 32'sh7fff_ffff);
    send_item(KIND_PUSH_FRONT, 32'sh8000_0000);
    send_item(KIND_PUSH_BACK, -32'sd1);
    send_item(KIND_PUSH_BACK, 32'sd0);
    send_item(KIND_PUSH_FRONT, 32'sd5);
    send_item(KIND_PUSH_BACK, 32'sd5);
    send_item(KIND_PUSH_FRONT, 32'sd5);
    send_item(KIND_EXISTS, 32'sd7);
    send_item(KIND_REM_FIRST, 32'sd7);
    send_item(KIND_REM_ALL, 32'sd7);
    send_item(KIND_EXISTS, 32'sh8000_0000);
    // remove-all must also drop the second 5 once the first leaves the head
    send_item(KIND_REM_ALL, 32'sd5);
    send_item(KIND_REM_FIRST, 32'sh7fff_ffff);
    send_item(KIND_REM_FIRST, 32'sd0);
    send_item(KIND_POP_FRONT, 32'sd0);
    send_item(KIND_POP_BACK, 32'sd0);
    send_item(KIND_PUSH_BACK, 32'sh5555_5555);
    send_item(KIND_PUSH_BACK, 32'shaaaa_aaaa);
    send_item(KIND_CLEAR, 32'sd0);

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 20) begin
        // fill to capacity and keep pushing a few more into the full store
        seg_len = DEPTH - sb.held_words.size() + $urandom_range(2, 5);
        repeat (seg_len) begin
          send_item($urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, pick_word());
        end
      end else begin
        seg_len = $urandom_range(15, 50);
        repeat (seg_len) begin
          op = pick_kind(r < 55);
          if (op == KIND_PUSH_FRONT || op == KIND_PUSH_BACK) begin
            send_item(op, pick_word());
          end else begin
            send_item(op, pick_key());
          end
        end
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    wait_cycles = 0;
    while (sb.pending_results.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);
    if (sb.pending_results.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d results never arrived", $time, sb.pending_results.size());
    end

    $display("Sent %0d transactions, checked %0d results, peak depth %0d of %0d.",
             items_sent, sb.checked, sb.peak_depth, DEPTH);
    $display("Pushes refused when full: %0d, empty-store hits: %0d, searches missed: %0d, words removed: %0d.",
             sb.full_rejects, sb.empty_hits, sb.misses, sb.removals);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout at %0t", $time);
    $display("TEST FAILED");
    $finish;
  end

endmodule
